@@ rtl/button_short_long_press_classifier_core_assert.svh @@
// assertion macros used by the checker file
`ifndef BUTTON_SHORT_LONG_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_SHORT_LONG_PRESS_CLASSIFIER_CORE_ASSERT_SVH

// clocked assertion, masked while reset is held
`define BSLP_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// same, checked during reset as well
`define BSLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/bslp_pkg.sv @@
// ----------------------------------------------------------------------------
// bslp_pkg
// Types and constants of the button short/long press classifier.
// ----------------------------------------------------------------------------
package bslp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESS_MODE    = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS_MS = 2'd1;
    localparam logic [1:0] CFG_BUTTON_NUMBER = 2'd2;

    // press modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_DUAL  = 2'd1;
    localparam logic [1:0] MODE_LEAVE = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd500;

    // one key sample
    typedef struct packed {
        logic        key_down;
        logic [31:0] now_ms;
    } bslp_in_t;

    // one button event
    typedef struct packed {
        logic       is_release;
        logic       long_event;
        logic       leave_flag;
        logic [7:0] event_button;
        logic       last_event;
    } bslp_out_t;

    // configuration seen by the classifier
    typedef struct packed {
        logic [1:0]  press_mode;
        logic [15:0] long_press_ms;
        logic [7:0]  button_number;
    } bslp_cfg_t;

    // events produced by one sample
    typedef struct packed {
        logic [1:0] count;
        bslp_out_t  ev0;
        bslp_out_t  ev1;
    } bslp_events_t;

endpackage

@@ rtl/bslp_classify.sv @@
// ----------------------------------------------------------------------------
// bslp_classify
// Press tracking state and the event decision for one key sample.
// ----------------------------------------------------------------------------
module bslp_classify
    import bslp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  bslp_in_t     sample,
    input  bslp_cfg_t    cfg,
    output bslp_events_t events
);

    logic        level_down_reg, level_down_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        press_done_reg, press_done_next;

    logic        dual;
    logic        leave;
    logic [31:0] held;
    logic        is_long;

    assign dual    = (cfg.press_mode == MODE_DUAL);
    assign leave   = (cfg.press_mode == MODE_LEAVE);
    assign held    = sample.now_ms - press_start_reg;
    assign is_long = (held >= {16'd0, cfg.long_press_ms});

    // event decision and next state
    always_comb begin
        bslp_out_t base;
        base = '{is_release: 1'b0, long_event: 1'b0, leave_flag: 1'b0,
                 event_button: cfg.button_number, last_event: 1'b0};
        level_down_next  = level_down_reg;
        press_start_next = press_start_reg;
        press_done_next  = press_done_reg;
        events.count     = 2'd0;
        events.ev0       = base;
        events.ev1       = base;
        if (!level_down_reg && sample.key_down) begin
            // press edge
            level_down_next = 1'b1;
            if (dual) begin
                press_start_next = sample.now_ms;
            end else begin
                if (!press_done_reg) begin
                    events.count          = 2'd1;
                    events.ev0.last_event = 1'b1;
                end
                press_done_next = 1'b1;
            end
        end else if (level_down_reg && sample.key_down) begin
            // key held: in dual mode, long press once the hold time is reached
            if (dual && !press_done_reg && is_long) begin
                events.count          = 2'd2;
                events.ev0.long_event = 1'b1;
                events.ev1.long_event = 1'b1;
                events.ev1.is_release = 1'b1;
                events.ev1.last_event = 1'b1;
                press_done_next       = 1'b1;
            end
        end else if (level_down_reg && !sample.key_down) begin
            // release edge
            level_down_next = 1'b0;
            press_done_next = 1'b0;
            if (dual) begin
                press_start_next = 32'd0;
                if (!is_long) begin
                    if (!press_done_reg) begin
                        events.count          = 2'd2;
                        events.ev1.is_release = 1'b1;
                        events.ev1.last_event = 1'b1;
                    end else begin
                        events.count          = 2'd1;
                        events.ev0.is_release = 1'b1;
                        events.ev0.last_event = 1'b1;
                    end
                end
            end else if (press_done_reg) begin
                events.count          = 2'd1;
                events.ev0.is_release = 1'b1;
                events.ev0.leave_flag = leave;
                events.ev0.last_event = 1'b1;
            end
        end
    end

    // tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_down_reg  <= 1'b0;
            press_start_reg <= 32'd0;
            press_done_reg  <= 1'b0;
        end else if (step) begin
            level_down_reg  <= level_down_next;
            press_start_reg <= press_start_next;
            press_done_reg  <= press_done_next;
        end
    end

endmodule

@@ rtl/bslp_outbuf.sv @@
// ----------------------------------------------------------------------------
// bslp_outbuf
// Two-entry result register that hands events out one per transfer.
// ----------------------------------------------------------------------------
module bslp_outbuf
    import bslp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  bslp_events_t events,
    output logic         can_load,
    output logic         m_valid,
    input  logic         m_ready,
    output bslp_out_t    m_data
);

    logic [1:0] count_reg, count_next;
    bslp_out_t  head_reg, head_next;
    bslp_out_t  tail_reg, tail_next;

    // room once the buffer empties in this cycle
    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = head_reg;

    // next contents
    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (m_valid && m_ready) begin
            count_next = count_reg - 2'd1;
            head_next  = tail_reg;
        end
        if (load && events.count != 2'd0) begin
            count_next = events.count;
            head_next  = events.ev0;
            tail_next  = events.ev1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

@@ rtl/button_short_long_press_classifier_core.sv @@
// ----------------------------------------------------------------------------
// button_short_long_press_classifier_core
// Classifies sampled key levels into short and long press/release events.
// ----------------------------------------------------------------------------
//   channel   ports                     payload
//   input     s_valid s_ready s_data    bslp_in_t  (key_down, now_ms)
//   result    m_valid m_ready m_data    bslp_out_t (one event per transfer)
//   config    cfg_we cfg_index cfg_data press_mode, long_press_ms, button_number
//
// Samples are taken every cycle while s_ready is high and classified in the input
// register; their zero, one or two events load into the two-entry result register.
// A sample giving events right after a two-event sample waits for room there.
// Reset is synchronous on aresetn and clears tracking state and config.
// A stalled result side backs up into s_ready once two samples with events are held.
// ----------------------------------------------------------------------------
module button_short_long_press_classifier_core
    import bslp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bslp_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bslp_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bslp_cfg_t    cfg_reg;
    logic         in_valid_reg;
    bslp_in_t     in_data_reg;
    bslp_events_t events;
    logic         can_load;
    logic         step;

    // a sample with no event never waits for the result side
    assign step    = in_valid_reg && (events.count == 2'd0 || can_load);
    assign s_ready = !in_valid_reg || step;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_mode    <= MODE_PLAIN;
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
            cfg_reg.button_number <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PRESS_MODE:    cfg_reg.press_mode    <= cfg_data[1:0];
                CFG_LONG_PRESS_MS: cfg_reg.long_press_ms <= cfg_data[15:0];
                CFG_BUTTON_NUMBER: cfg_reg.button_number <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    bslp_classify u_classify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .sample  (in_data_reg),
        .cfg     (cfg_reg),
        .events  (events)
    );

    bslp_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .events   (events),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/bslp_checker.sv @@
// ----------------------------------------------------------------------------
// bslp_checker
// Port-level checks of the press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_short_long_press_classifier_core_assert.svh"

module bslp_checker
    import bslp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input bslp_out_t m_data
);

    // a stalled event holds
    `BSLP_ASSERT_CLK(a_hold,
        m_valid && !m_ready |=> m_valid && $stable(m_data),
        "event changed while stalled")

    // a long press is followed at once by its long release
    `BSLP_ASSERT_CLK(a_long_pair,
        m_valid && m_ready && m_data.long_event && !m_data.is_release
            |=> m_valid && m_data.long_event && m_data.is_release,
        "long press without long release")

    // a release always closes the events of its sample
    `BSLP_ASSERT_CLK(a_rel_last,
        m_valid && m_data.is_release |-> m_data.last_event,
        "release not last")

    // leave flag only on a short release
    `BSLP_ASSERT_ALWAYS(a_leave,
        m_valid && m_data.leave_flag |-> m_data.is_release && !m_data.long_event,
        "leave flag on wrong event")

endmodule

bind button_short_long_press_classifier_core bslp_checker u_bslp_checker (.*);
